// File: rtl/core/ads_pkg.sv
// ads_pkg: shared widths, constants, register indexes and fixed-point helpers
// for the allpass delay coefficient search unit
// no dependencies
package ads_pkg;

    // field and datapath widths
    localparam int SW    = 16;       // sample width
    localparam int MEMW  = 24;       // allpass section memory width
    localparam int MW    = 25;       // multiplier operand width
    localparam int PW    = 2 * MW;   // multiplier product width
    localparam int ACCW  = 48;       // error accumulator width
    localparam int RW    = 18;       // coefficient register width
    localparam int ERRW  = 36;       // output error width
    localparam int IDXW  = 8;        // grid index width
    localparam int GPW   = 9;        // grid_points register width
    localparam int GIW   = 6;        // golden_iterations register width
    localparam int QW    = PW - 15;  // rounded product width

    // coefficient constants in Q1.15
    localparam logic signed [RW-1:0] R_LOW      = -18'sd31130;
    localparam logic signed [MW-1:0] R_SPAN     = 25'sd62259;
    localparam logic signed [MW-1:0] GOLDEN_Q15 = 25'sd12516;
    localparam logic signed [RW-1:0] COEF_MAX   = 18'sd32767;
    localparam logic signed [RW-1:0] COEF_LIM   = 18'sd32768;
    localparam logic [IDXW-1:0]      WINDOW     = 8'd5;

    // saturation limits
    localparam logic [ACCW-1:0] ACC_MAX = {ACCW{1'b1}};
    localparam logic [ERRW-1:0] ERR_MAX = {ERRW{1'b1}};

    // configuration register indexes
    localparam logic CFG_GRID_POINTS = 1'b0;
    localparam logic CFG_GOLDEN_ITER = 1'b1;

    // defaults after reset
    localparam logic [GPW-1:0] GP_RESET = 9'd64;
    localparam logic [GIW-1:0] GI_RESET = 6'd20;

    // product rounded half up by a 15-bit shift (floor of (x + 2^14) / 2^15)
    function automatic logic signed [QW-1:0] round_q15(input logic signed [PW-1:0] prod);
        logic signed [PW-1:0] t;
        begin
            t = prod + 50'sd16384;
            round_q15 = t[PW-1:15];
        end
    endfunction

    // section output: rounded product plus memory, saturated to 24 bits
    function automatic logic signed [MEMW-1:0] section_out(
        input logic signed [PW-1:0]   prod,
        input logic signed [MEMW-1:0] mem
    );
        logic signed [QW-1:0] q;
        logic signed [QW:0]   s;
        begin
            q = round_q15(prod);
            s = {q[QW-1], q} + {{(QW + 1 - MEMW){mem[MEMW-1]}}, mem};
            if (s > $signed({{(QW + 2 - MEMW){1'b0}}, {(MEMW - 1){1'b1}}}))
                section_out = {1'b0, {(MEMW - 1){1'b1}}};
            else if (s < $signed({{(QW + 2 - MEMW){1'b1}}, {(MEMW - 1){1'b0}}}))
                section_out = {1'b1, {(MEMW - 1){1'b0}}};
            else
                section_out = s[MEMW-1:0];
        end
    endfunction

endpackage

// File: rtl/core/ads_if.sv
// ads_if: handshake channels for sample items and result items
// depends on ads_pkg
interface ads_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [ads_pkg::SW-1:0] signal_sample;
    logic signed [ads_pkg::SW-1:0] reference_sample;
    logic                          last_sample;

    modport source (output valid, signal_sample, reference_sample, last_sample, input ready);
    modport sink   (input valid, signal_sample, reference_sample, last_sample, output ready);
endinterface

interface ads_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [ads_pkg::SW-1:0]   coefficient_estimate;
    logic        [ads_pkg::ERRW-1:0] grid_min_error;
    logic        [ads_pkg::IDXW-1:0] grid_min_index;

    modport source (output valid, coefficient_estimate, grid_min_error, grid_min_index,
                    input ready);
    modport sink   (input valid, coefficient_estimate, grid_min_error, grid_min_index,
                    output ready);
endinterface

// File: rtl/core/ads_ram.sv
// ads_ram: generic single-write, single-read memory with registered read
// no dependencies
module ads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/ads_div.sv
// ads_div: restoring divider, one quotient bit per cycle
// no dependencies
module ads_div #(
    parameter int NW = 48,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CNTW = $clog2(NW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;
    logic [DW-1:0]   rem_next;
    logic [NW-1:0]   quo_next;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: rtl/core/ads_mul.sv
// ads_mul: shared signed multiplier with registered product
// depends on ads_pkg
module ads_mul (
    input  logic                          clk,
    input  logic signed [ads_pkg::MW-1:0] op_a,
    input  logic signed [ads_pkg::MW-1:0] op_b,
    output logic signed [ads_pkg::PW-1:0] prod
);
    import ads_pkg::*;

    logic signed [PW-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;
endmodule

// File: rtl/core/allpass_delay_coefficient_search_unit.sv
// allpass_delay_coefficient_search_unit: sample store, search sequencer and datapath
// depends on ads_pkg, ads_if, ads_ram, ads_div, ads_mul
//
//   channel   dir   handshake      payload
//   samples   in    valid/ready    signal_sample, reference_sample, last_sample
//   result    out   valid/ready    coefficient_estimate, grid_min_error, grid_min_index
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// a sample item without last is taken into the store; an item with last runs the search
// one objective evaluation over n stored pairs is five steps per pair with three multiplier
// passes, then the 48-step divide for the mean; each grid point and each window end adds
// a coefficient divide, each golden step computes two inner points; a search is grid_points +
// 2*golden_iterations evaluations (as clamped); samples.ready is low from the last item
// until the result is loaded, and a waiting result does not block the next sample items
module allpass_delay_coefficient_search_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ads_in_if.sink                      samples,
    ads_out_if.source                   result,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ads_pkg::GPW-1:0]     cfg_data
);
    import ads_pkg::*;

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int DVW = (CW > GPW) ? CW : GPW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GMUL  = 4'd1;
    localparam logic [3:0] S_GDIV  = 4'd2;
    localparam logic [3:0] S_GWAIT = 4'd3;
    localparam logic [3:0] S_OADDR = 4'd4;
    localparam logic [3:0] S_OM1   = 4'd5;
    localparam logic [3:0] S_OM2   = 4'd6;
    localparam logic [3:0] S_OM3   = 4'd7;
    localparam logic [3:0] S_OACC  = 4'd8;
    localparam logic [3:0] S_ODIV  = 4'd9;
    localparam logic [3:0] S_OWAIT = 4'd10;
    localparam logic [3:0] S_GOLD1 = 4'd11;
    localparam logic [3:0] S_GOLD2 = 4'd12;
    localparam logic [3:0] S_GOLD3 = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // what the current coefficient or objective is for
    localparam logic [2:0] PH_GRID = 3'd0;
    localparam logic [2:0] PH_LO   = 3'd1;
    localparam logic [2:0] PH_HI   = 3'd2;
    localparam logic [2:0] PH_C    = 3'd3;
    localparam logic [2:0] PH_D    = 3'd4;

    logic [3:0]              state_reg, state_next;
    logic [2:0]              phase_reg, phase_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [IDXW-1:0]         gidx_reg, gidx_next;
    logic [IDXW-1:0]         hi_reg, hi_next;
    logic [GIW-1:0]          step_reg, step_next;
    logic signed [RW-1:0]    r_reg, r_next;
    logic signed [RW-1:0]    lower_reg, lower_next;
    logic signed [RW-1:0]    upper_reg, upper_next;
    logic signed [RW-1:0]    c_reg, c_next;
    logic signed [RW-1:0]    d_reg, d_next;
    logic [ACCW-1:0]         fc_reg, fc_next;
    logic signed [MEMW-1:0]  m0_reg, m0_next, m1_reg, m1_next;
    logic signed [MEMW-1:0]  n0_reg, n0_next, n1_reg, n1_next;
    logic [ACCW-1:0]         acc_reg, acc_next;
    logic [ACCW-1:0]         best_err_reg, best_err_next;
    logic [IDXW-1:0]         best_idx_reg, best_idx_next;
    logic [GPW-1:0]          gp_reg, gp_next;
    logic [GIW-1:0]          gi_reg, gi_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    out_coef_reg, out_coef_next;
    logic [ERRW-1:0]         out_err_reg, out_err_next;
    logic [IDXW-1:0]         out_idx_reg, out_idx_next;

    logic [GPW-1:0]          n_eff;
    logic [GPW-1:0]          n_last;
    logic [GIW-1:0]          iters_eff;
    logic                    in_take;
    logic                    ram_we;
    logic [2*SW-1:0]         ram_rdata;
    logic signed [SW-1:0]    u_smp;
    logic signed [SW-1:0]    ref_smp;
    logic signed [MW-1:0]    op_a, op_b;
    logic signed [PW-1:0]    prod;
    logic                    div_start;
    logic [ACCW-1:0]         div_dividend;
    logic [DVW-1:0]          div_divisor;
    logic                    div_done;
    logic [ACCW-1:0]         div_quo;
    logic signed [MEMW-1:0]  y1, y2;
    logic signed [MW-1:0]    e_val;
    logic [PW:0]             acc_sum;
    logic signed [RW-1:0]    gv;
    logic signed [RW-1:0]    c_calc, d_calc, new_lower;
    logic                    upd_best;
    logic [IDXW-1:0]         win_best;
    logic [GPW-1:0]          win_hi;
    logic signed [QW-1:0]    rq;

    // clamp registers at use
    always_comb
    begin
        if (gp_reg < 9'd2)
            n_eff = 9'd2;
        else if (gp_reg > 9'd256)
            n_eff = 9'd256;
        else
            n_eff = gp_reg;
        n_last = n_eff - 9'd1;
        if (gi_reg == '0)
            iters_eff = 6'd1;
        else if (gi_reg > 6'd32)
            iters_eff = 6'd32;
        else
            iters_eff = gi_reg;
    end

    // sample store: signal in the upper half, reference in the lower half
    assign in_take = samples.valid && samples.ready;
    assign ram_we  = in_take && (count_reg < CW'(MAX_SAMPLES));

    ads_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({samples.signal_sample, samples.reference_sample}),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign u_smp   = $signed(ram_rdata[2*SW-1:SW]);
    assign ref_smp = $signed(ram_rdata[SW-1:0]);

    // allpass section outputs from the registered product
    assign y1    = section_out(prod, m0_reg);
    assign y2    = section_out(prod, n0_reg);
    assign e_val = {y2[MEMW-1], y2} - {{(MW - SW){ref_smp[SW-1]}}, ref_smp};
    assign rq    = round_q15(prod);

    // golden points
    assign c_calc = lower_reg + $signed(rq[RW-1:0]);
    assign d_calc = c_reg + $signed(rq[RW-1:0]);

    // grid coefficient from the divider quotient
    assign gv = R_LOW + $signed(div_quo[RW-1:0]);

    // multiplier operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_GMUL:
            begin
                op_a = $signed({{(MW - IDXW){1'b0}}, gidx_reg});
                op_b = R_SPAN;
            end
            S_OM1:
            begin
                op_a = {{(MW - RW){r_reg[RW-1]}}, r_reg};
                op_b = {m1_reg[MEMW-1], m1_reg} - {{(MW - SW){u_smp[SW-1]}}, u_smp};
            end
            S_OM2:
            begin
                op_a = {{(MW - RW){r_reg[RW-1]}}, r_reg};
                op_b = {n1_reg[MEMW-1], n1_reg} - {y1[MEMW-1], y1};
            end
            S_OM3:
            begin
                op_a = e_val;
                op_b = e_val;
            end
            S_GOLD1:
            begin
                op_a = GOLDEN_Q15;
                op_b = {{(MW - RW){upper_reg[RW-1]}}, upper_reg}
                     - {{(MW - RW){lower_reg[RW-1]}}, lower_reg};
            end
            S_GOLD2:
            begin
                op_a = GOLDEN_Q15;
                op_b = {{(MW - RW){upper_reg[RW-1]}}, upper_reg}
                     - {{(MW - RW){c_calc[RW-1]}}, c_calc};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    ads_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // divider operand selection
    always_comb
    begin
        div_start    = (state_reg == S_GDIV) || (state_reg == S_ODIV);
        div_dividend = (state_reg == S_GDIV) ? prod[ACCW-1:0] : acc_reg;
        div_divisor  = (state_reg == S_GDIV) ? DVW'(n_last) : DVW'(count_reg);
    end

    ads_div #(
        .NW (ACCW),
        .DW (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // saturating error accumulation
    assign acc_sum = {{(PW + 1 - ACCW){1'b0}}, acc_reg} + {1'b0, prod};

    // grid minimum and search window
    always_comb
    begin
        upd_best = (gidx_reg == '0) || (div_quo < best_err_reg);
        win_best = upd_best ? gidx_reg : best_idx_reg;
        win_hi   = {1'b0, win_best} + {1'b0, WINDOW};
        if (win_hi > n_last)
            win_hi = n_last;
        new_lower = (fc_reg <= div_quo) ? lower_reg : c_reg;
        if ((new_lower > COEF_LIM) || (new_lower < -COEF_LIM))
            new_lower = COEF_MAX;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        gidx_next      = gidx_reg;
        hi_next        = hi_reg;
        step_next      = step_reg;
        r_next         = r_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        fc_next        = fc_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        acc_next       = acc_reg;
        best_err_next  = best_err_reg;
        best_idx_next  = best_idx_reg;
        gp_next        = gp_reg;
        gi_next        = gi_reg;
        out_valid_next = out_valid_reg;
        out_coef_next  = out_coef_reg;
        out_err_next   = out_err_reg;
        out_idx_next   = out_idx_reg;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_POINTS: gp_next = cfg_data;
                CFG_GOLDEN_ITER: gi_next = cfg_data[GIW-1:0];
                default:         gp_next = gp_reg;
            endcase
        end

        // result handed over
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (samples.last_sample)
                    begin
                        gidx_next  = '0;
                        phase_next = PH_GRID;
                        state_next = S_GMUL;
                    end
                end
            end
            S_GMUL:
            begin
                state_next = S_GDIV;
            end
            S_GDIV:
            begin
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                if (div_done)
                begin
                    priority if (phase_reg == PH_LO)
                    begin
                        lower_next = gv;
                        gidx_next  = hi_reg;
                        phase_next = PH_HI;
                        state_next = S_GMUL;
                    end
                    else if (phase_reg == PH_HI)
                    begin
                        upper_next = gv;
                        step_next  = '0;
                        state_next = S_GOLD1;
                    end
                    else
                    begin
                        r_next     = gv;
                        k_next     = '0;
                        m0_next    = '0;
                        m1_next    = '0;
                        n0_next    = '0;
                        n1_next    = '0;
                        acc_next   = '0;
                        state_next = S_OADDR;
                    end
                end
            end
            S_OADDR:
            begin
                state_next = S_OM1;
            end
            S_OM1:
            begin
                state_next = S_OM2;
            end
            S_OM2:
            begin
                m0_next    = {{(MEMW - SW){u_smp[SW-1]}}, u_smp};
                m1_next    = y1;
                state_next = S_OM3;
            end
            S_OM3:
            begin
                n0_next    = m1_reg;
                n1_next    = y2;
                state_next = S_OACC;
            end
            S_OACC:
            begin
                if (acc_sum > {{(PW + 1 - ACCW){1'b0}}, ACC_MAX})
                    acc_next = ACC_MAX;
                else
                    acc_next = acc_sum[ACCW-1:0];
                if (k_reg == count_reg - 1'b1)
                begin
                    state_next = S_ODIV;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_OADDR;
                end
            end
            S_ODIV:
            begin
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (div_done)
                begin
                    priority if (phase_reg == PH_C)
                    begin
                        fc_next    = div_quo;
                        r_next     = d_reg;
                        k_next     = '0;
                        m0_next    = '0;
                        m1_next    = '0;
                        n0_next    = '0;
                        n1_next    = '0;
                        acc_next   = '0;
                        phase_next = PH_D;
                        state_next = S_OADDR;
                    end
                    else if (phase_reg == PH_D)
                    begin
                        if (fc_reg <= div_quo)
                            upper_next = d_reg;
                        lower_next = new_lower;
                        step_next  = step_reg + 1'b1;
                        if (step_reg == iters_eff - 6'd1)
                            state_next = S_OUT;
                        else
                            state_next = S_GOLD1;
                    end
                    else
                    begin
                        if (upd_best)
                        begin
                            best_err_next = div_quo;
                            best_idx_next = gidx_reg;
                        end
                        if ({1'b0, gidx_reg} == n_last)
                        begin
                            gidx_next  = (win_best >= WINDOW) ? (win_best - WINDOW) : '0;
                            hi_next    = win_hi[IDXW-1:0];
                            phase_next = PH_LO;
                        end
                        else
                        begin
                            gidx_next = gidx_reg + 1'b1;
                        end
                        state_next = S_GMUL;
                    end
                end
            end
            S_GOLD1:
            begin
                state_next = S_GOLD2;
            end
            S_GOLD2:
            begin
                c_next     = c_calc;
                state_next = S_GOLD3;
            end
            S_GOLD3:
            begin
                d_next     = d_calc;
                r_next     = c_reg;
                k_next     = '0;
                m0_next    = '0;
                m1_next    = '0;
                n0_next    = '0;
                n1_next    = '0;
                acc_next   = '0;
                phase_next = PH_C;
                state_next = S_OADDR;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = (lower_reg > COEF_MAX) ? COEF_MAX[SW-1:0]
                                                            : lower_reg[SW-1:0];
                    out_err_next   = (best_err_reg > {{(ACCW - ERRW){1'b0}}, ERR_MAX})
                                   ? ERR_MAX : best_err_reg[ERRW-1:0];
                    out_idx_next   = best_idx_reg;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_GRID;
            count_reg     <= '0;
            k_reg         <= '0;
            gidx_reg      <= '0;
            hi_reg        <= '0;
            step_reg      <= '0;
            r_reg         <= '0;
            lower_reg     <= '0;
            upper_reg     <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            fc_reg        <= '0;
            m0_reg        <= '0;
            m1_reg        <= '0;
            n0_reg        <= '0;
            n1_reg        <= '0;
            acc_reg       <= '0;
            best_err_reg  <= '0;
            best_idx_reg  <= '0;
            gp_reg        <= GP_RESET;
            gi_reg        <= GI_RESET;
            out_valid_reg <= 1'b0;
            out_coef_reg  <= '0;
            out_err_reg   <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            gidx_reg      <= gidx_next;
            hi_reg        <= hi_next;
            step_reg      <= step_next;
            r_reg         <= r_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            fc_reg        <= fc_next;
            m0_reg        <= m0_next;
            m1_reg        <= m1_next;
            n0_reg        <= n0_next;
            n1_reg        <= n1_next;
            acc_reg       <= acc_next;
            best_err_reg  <= best_err_next;
            best_idx_reg  <= best_idx_next;
            gp_reg        <= gp_next;
            gi_reg        <= gi_next;
            out_valid_reg <= out_valid_next;
            out_coef_reg  <= out_coef_next;
            out_err_reg   <= out_err_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // channel outputs
    assign samples.ready               = (state_reg == S_IDLE);
    assign result.valid                = out_valid_reg;
    assign result.coefficient_estimate = out_coef_reg;
    assign result.grid_min_error       = out_err_reg;
    assign result.grid_min_index       = out_idx_reg;
endmodule
